// ----- design/sccd_pkg.sv -----
// Shared types and constants of the sector cache tag directory.
package sccd_pkg;

  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef logic [SECTOR_W-1:0] sector_t;

  // All ones marks an empty tag and an empty write buffer.
  localparam sector_t EMPTY_TAG = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BUF_READ    = 3'd0,
    ACT_READ_HIT    = 3'd1,
    ACT_READ_FILL   = 3'd2,
    ACT_WRITE_HIT   = 3'd3,
    ACT_WRITE_ALLOC = 3'd4,
    ACT_BUFFERED    = 3'd5,
    ACT_NOTHING     = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_PLACE = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

endpackage

// ----- design/sccd_tag_cell.sv -----
// One tag cell of the rotating tag ring.
module sccd_tag_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  sccd_pkg::sector_t tag_i,
  output sccd_pkg::sector_t tag_o
);
  import sccd_pkg::*;

  sector_t tag_q, tag_d;

  // Take the neighbor's tag while the ring rotates, hold otherwise.
  always_comb begin
    tag_d = shift_i ? tag_i : tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= EMPTY_TAG;
    end else begin
      tag_q <= tag_d;
    end
  end

  assign tag_o = tag_q;

endmodule

// ----- design/sector_cache_directory_fifo_core.sv -----
// Top level: FIFO-replacement sector cache tag directory with write buffer.
// A result needing no tag lookup (buffer read, buffered write, empty flush, undefined
//   function) needs no ring pass; a hit takes one ring pass, a miss a second to place.
// One request at a time: the next is taken once the last result of the previous one
//   is loaded for output; a displacing buffered write gives two results.
// Reset: all tags empty, ring pointer 0, buffer empty, buffer disabled, at once.
module sector_cache_directory_fifo_core #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: write_buffer_enabled
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [1:0] func, [33:2] sector, rest zero
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [2:0] action, [34:3] target_sector,
                                        // [40:35] slot, rest zero
  output logic        m_axis_tlast_o    // last result of the request
);
  import sccd_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LastIdx = SW'(SLOTS - 1);

  // ---------------------------------------------------------------------------
  // Tag ring: cell 0 is the head. Each rotation step moves every tag one cell
  // toward the head and feeds the head tag back into the tail. A full pass is
  // exactly SLOTS steps, so between requests cell i always holds slot i and
  // the step counter doubles as the index of the tag sitting at the head.
  // ---------------------------------------------------------------------------
  sector_t          ring_tag [SLOTS];
  sector_t          tail_in;
  logic             shift_en;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sector_t nb_tag;
    if (g == SLOTS - 1) begin : g_tail
      assign nb_tag = tail_in;
    end else begin : g_mid
      assign nb_tag = ring_tag[g+1];
    end
    sccd_tag_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_en),
      .tag_i  (nb_tag),
      .tag_o  (ring_tag[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Control and result registers
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [SW-1:0]   cnt_q;          // rotation step = index of head tag
  logic [SW-1:0]   ring_ptr_q;     // next slot to replace
  sector_t         pending_q;      // buffered sector, EMPTY_TAG when none
  logic            buf_en_q;       // write_buffer_enabled
  logic            op_write_q;     // lookup is for a write-through
  logic            follow_q;       // a buffered result follows this one
  sector_t         buf_sec_q;      // sector of the following buffered result
  logic            found_q;
  logic [SW-1:0]   hit_idx_q;

  action_e         res_action_q;
  sector_t         res_sector_q;   // also the lookup key
  logic [SW-1:0]   res_slot_q;
  logic            res_last_q;

  logic            m_valid_q;
  action_e         m_action_q;
  sector_t         m_sector_q;
  logic [SW-1:0]   m_slot_q;
  logic            m_last_q;

  // Incoming request fields
  func_e           in_func;
  sector_t         in_sec;
  assign in_func = func_e'(s_axis_tdata_i[FUNC_W-1:0]);
  assign in_sec  = s_axis_tdata_i[FUNC_W +: SECTOR_W];

  logic accept;
  logic start_scan;
  logic out_free;
  logic load_out;
  logic write_head;
  logic last_step;
  logic hit_now;
  logic hit_any;
  logic pend_valid;

  assign pend_valid = (pending_q != EMPTY_TAG);
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign last_step  = (cnt_q == LastIdx);

  // The empty marker never hits; a lookup of it allocates the ring slot.
  assign hit_now = (ring_tag[0] == res_sector_q) && (res_sector_q != EMPTY_TAG);
  assign hit_any = found_q || hit_now;

  // Drop the key into the tail as the target slot passes the head.
  assign tail_in = write_head ? res_sector_q : ring_tag[0];

  // Decide at acceptance whether the request needs a tag lookup.
  always_comb begin
    start_scan = 1'b0;
    unique case (in_func)
      FUNC_READ: begin
        start_scan = !(buf_en_q && pend_valid && (pending_q == in_sec));
      end
      FUNC_WRITE: begin
        start_scan = !buf_en_q || (pend_valid && (pending_q != in_sec));
      end
      FUNC_FLUSH: begin
        start_scan = pend_valid;
      end
      default: begin
        start_scan = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = start_scan ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_d = hit_any ? ST_EMIT : ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (last_step) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && !follow_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    shift_en        = (state_q == ST_SCAN) || (state_q == ST_PLACE);
    load_out        = (state_q == ST_EMIT) && out_free;
    write_head      = (state_q == ST_PLACE) && (cnt_q == res_slot_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      ring_ptr_q <= '0;
      pending_q  <= EMPTY_TAG;
      buf_en_q   <= 1'b0;
      follow_q   <= 1'b0;
      found_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        buf_en_q <= cfg_wdata_i;
      end

      // Advance the rotation counter; it wraps back to 0 after a full pass.
      if (shift_en) begin
        cnt_q <= last_step ? '0 : cnt_q + 1'b1;
      end

      if (accept) begin
        found_q  <= 1'b0;
        follow_q <= 1'b0;
        unique case (in_func)
          FUNC_WRITE: begin
            if (buf_en_q) begin
              pending_q <= in_sec;
              follow_q  <= pend_valid && (pending_q != in_sec);
            end
          end
          FUNC_FLUSH: begin
            pending_q <= EMPTY_TAG;
          end
          default: begin
          end
        endcase
      end

      // Remember the lowest matching slot during the pass.
      if ((state_q == ST_SCAN) && hit_now && !found_q) begin
        found_q <= 1'b1;
      end

      // Claim the ring slot at the end of a missing pass.
      if ((state_q == ST_SCAN) && last_step && !hit_any) begin
        ring_ptr_q <= (ring_ptr_q == LastIdx) ? '0 : ring_ptr_q + 1'b1;
      end

      if (load_out) begin
        m_valid_q <= 1'b1;
        if (follow_q) begin
          follow_q <= 1'b0;
        end
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_sec_q  <= in_sec;
      op_write_q <= (in_func != FUNC_READ);
      res_slot_q <= '0;
      res_last_q <= 1'b1;
      unique case (in_func)
        FUNC_READ: begin
          res_sector_q <= in_sec;
          res_action_q <= ACT_BUF_READ;
        end
        FUNC_WRITE: begin
          if (buf_en_q && pend_valid && (pending_q != in_sec)) begin
            res_sector_q <= pending_q;
            res_last_q   <= 1'b0;
          end else begin
            res_sector_q <= in_sec;
          end
          res_action_q <= ACT_BUFFERED;
        end
        FUNC_FLUSH: begin
          res_sector_q <= pend_valid ? pending_q : '0;
          res_action_q <= ACT_NOTHING;
        end
        default: begin
          res_sector_q <= '0;
          res_action_q <= ACT_NOTHING;
        end
      endcase
    end

    if ((state_q == ST_SCAN) && hit_now && !found_q) begin
      hit_idx_q <= cnt_q;
    end

    if ((state_q == ST_SCAN) && last_step) begin
      if (hit_any) begin
        res_action_q <= op_write_q ? ACT_WRITE_HIT : ACT_READ_HIT;
        res_slot_q   <= found_q ? hit_idx_q : cnt_q;
      end else begin
        res_action_q <= op_write_q ? ACT_WRITE_ALLOC : ACT_READ_FILL;
        res_slot_q   <= ring_ptr_q;
      end
    end

    if (load_out) begin
      m_action_q <= res_action_q;
      m_sector_q <= res_sector_q;
      m_slot_q   <= res_slot_q;
      m_last_q   <= res_last_q;
      // Queue the buffered result behind the write-out of the old sector.
      if (follow_q) begin
        res_action_q <= ACT_BUFFERED;
        res_sector_q <= buf_sec_q;
        res_slot_q   <= '0;
        res_last_q   <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output packing
  // ---------------------------------------------------------------------------
  logic [SW+SLOT_W-1:0] slot_ext;
  assign slot_ext = {{SLOT_W{1'b0}}, m_slot_q};

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {
    {(OUT_TDATA_W - ACTION_W - SECTOR_W - SLOT_W){1'b0}},
    slot_ext[SLOT_W-1:0],
    m_sector_q,
    m_action_q
  };

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Every pass is a full rotation, so the ring is aligned whenever idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("tag ring misaligned while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_ptr_q <= LastIdx)
    else $error("ring pointer out of range");

  // The placed tag lands in the tail cell in the cycle after it passes the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_head |=> (ring_tag[SLOTS-1] == $past(res_sector_q)))
    else $error("allocated tag not written into the ring");

  // Only a write-out of the old buffered sector is a non-final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_last_q) |->
      ((m_action_q == ACT_WRITE_HIT) || (m_action_q == ACT_WRITE_ALLOC)))
    else $error("non-final result with unexpected action");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the FIFO sector cache tag directory and its write buffer.
module tb;
  import sccd_pkg::*;

  localparam int unsigned SLOTS           = 64;
  // Watchdog limit on the whole run, counted from time zero.
  localparam int unsigned LIMIT_CYCLES    = 600000;
  localparam int unsigned SETTLE_CYCLES   = 2 * SLOTS + 16;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS     = 75;
  // Code 3 is not a defined function; the block answers it with "nothing".
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    action_e           action;
    sector_t           target;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } dir_result_t;

  // DUT ports
  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // [1:0] func, [33:2] sector, rest zero
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [2:0] action, [34:3] target_sector,
                                            // [40:35] slot, rest zero
  logic                   m_axis_tlast_o;

  // Shadow copy of the directory state
  sector_t           tag_dir [SLOTS];
  int unsigned       ring_ptr;
  sector_t           buffered_sector;
  logic              wbuf_en;

  // Predicted results, oldest first
  dir_result_t       action_q [$];

  // Run bookkeeping
  int unsigned       errors;
  int unsigned       cycle_count;
  int unsigned       items_sent;
  int unsigned       results_checked;
  int unsigned       cfg_writes;
  int unsigned       action_count [7];

  // Flow control knobs shared by the tests and the result sink
  bit                source_steady;
  bit                sink_steady;
  bit                hold_off_req;

  // Checker scratch
  dir_result_t       want;
  logic [ACTION_W-1:0] got_action;
  sector_t           got_target;
  logic [SLOT_W-1:0] got_slot;

  sector_cache_directory_fifo_core #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Lowest slot holding the sector; the empty marker never matches.
  function automatic int find_tag(input sector_t sec);
    if (sec == EMPTY_TAG) return -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_dir[i] == sec) return i;
    end
    return -1;
  endfunction

  // Replace the slot under the ring pointer and advance the pointer.
  function automatic logic [SLOT_W-1:0] place_tag(input sector_t sec);
    int unsigned s;
    s = ring_ptr % SLOTS;
    tag_dir[s] = sec;
    ring_ptr = (s + 1) % SLOTS;
    return s[SLOT_W-1:0];
  endfunction

  task automatic push_action(input action_e act, input sector_t sec,
                             input logic [SLOT_W-1:0] slot, input logic last);
    dir_result_t r;
    r.action = act;
    r.target = sec;
    r.slot   = slot;
    r.last   = last;
    action_q.push_back(r);
  endtask

  // Write-through: update a matching slot or allocate the ring slot.
  task automatic predict_write_out(input sector_t sec, input logic last);
    int h;
    h = find_tag(sec);
    if (h >= 0) begin
      push_action(ACT_WRITE_HIT, sec, h[SLOT_W-1:0], last);
    end else begin
      push_action(ACT_WRITE_ALLOC, sec, place_tag(sec), last);
    end
  endtask

  task automatic predict_actions(input logic [FUNC_W-1:0] fn, input sector_t sec);
    int      h;
    sector_t old;
    case (fn)
      FUNC_READ: begin
        if (wbuf_en && buffered_sector != EMPTY_TAG && buffered_sector == sec) begin
          push_action(ACT_BUF_READ, sec, '0, 1'b1);
        end else begin
          h = find_tag(sec);
          if (h >= 0) push_action(ACT_READ_HIT, sec, h[SLOT_W-1:0], 1'b1);
          else        push_action(ACT_READ_FILL, sec, place_tag(sec), 1'b1);
        end
      end
      FUNC_WRITE: begin
        if (!wbuf_en) begin
          predict_write_out(sec, 1'b1);
        end else begin
          // Write out a different pending sector before parking this one
          if (buffered_sector != EMPTY_TAG && buffered_sector != sec) begin
            predict_write_out(buffered_sector, 1'b0);
          end
          buffered_sector = sec;
          push_action(ACT_BUFFERED, sec, '0, 1'b1);
        end
      end
      FUNC_FLUSH: begin
        if (buffered_sector != EMPTY_TAG) begin
          old = buffered_sector;
          buffered_sector = EMPTY_TAG;
          predict_write_out(old, 1'b1);
        end else begin
          push_action(ACT_NOTHING, '0, '0, 1'b1);
        end
      end
      default: begin
        push_action(ACT_NOTHING, '0, '0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request source, result sink and checker
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the transaction completes. Valid stays
  // high afterwards; drain_results or a gap in the next call lowers it.
  task automatic send_request(input logic [FUNC_W-1:0] fn, input sector_t sec);
    int gap;
    gap = source_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_actions(fn, sec);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - SECTOR_W - FUNC_W){1'b0}}, sec, fn};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (action_q.size() != 0) @(posedge clk_i);
  endtask

  // A register write is to come only while the block is idle, which the block does not enforce, so drain first.
  task automatic write_buffer_cfg(input logic en);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    wbuf_en = en;
    cfg_writes++;
  endtask

  // Result sink: random stalls per result, plus a long hold-off on request.
  initial begin : result_sink
    int gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      gap = sink_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid_o && m_axis_tready_i)) @(posedge clk_i);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
             $time, field, exp_val, act_val);
  endtask

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_action = m_axis_tdata_o[ACTION_W-1:0];
      got_target = m_axis_tdata_o[ACTION_W +: SECTOR_W];
      got_slot   = m_axis_tdata_o[ACTION_W + SECTOR_W +: SLOT_W];
      if (action_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual action %0d sector 0x%0h",
                 $time, got_action, got_target);
      end else begin
        want = action_q.pop_front();
        results_checked++;
        action_count[want.action]++;
        if (got_action !== want.action)
          report_mismatch("action", want.action, got_action);
        if (got_target !== want.target)
          report_mismatch("target_sector", want.target, got_target);
        if (got_slot !== want.slot)
          report_mismatch("slot", want.slot, got_slot);
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last", want.last, m_axis_tlast_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, action_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly a small pool so tags get hit and evicted, some near the empty
  // marker, the rest full-width to toggle every bit.
  function automatic sector_t random_sector();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)      return sector_t'($urandom_range(0, 95));
    else if (r < 70) return EMPTY_TAG - sector_t'($urandom_range(0, 24));
    else             return sector_t'($urandom);
  endfunction

  function automatic logic [FUNC_W-1:0] random_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      return FUNC_READ;
    else if (r < 83) return FUNC_WRITE;
    else if (r < 95) return FUNC_FLUSH;
    else             return FUNC_UNUSED;
  endfunction

  task automatic send_random_request();
    logic [FUNC_W-1:0] fn;
    sector_t           sec;
    fn  = random_func();
    sec = random_sector();
    // Aim at the parked sector often enough to exercise buffer reads and
    // same-sector writes.
    if (wbuf_en && buffered_sector != EMPTY_TAG && $urandom_range(0, 3) == 0)
      sec = buffered_sector;
    send_request(fn, sec);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Buffer off after reset: fills, hits, extreme sectors, empty marker, no-ops.
  task automatic test_write_through();
    send_request(FUNC_READ,   32'h0000_0000);   // fill slot 0
    send_request(FUNC_READ,   32'h0000_0000);   // hit slot 0
    send_request(FUNC_READ,   32'hFFFF_FFFE);   // fill, top sector
    send_request(FUNC_READ,   EMPTY_TAG);       // takes ring slot, stays empty
    send_request(FUNC_READ,   EMPTY_TAG);       // never hits
    send_request(FUNC_WRITE,  32'hFFFF_FFFE);   // write hit
    send_request(FUNC_WRITE,  32'h0000_0005);   // write allocate
    send_request(FUNC_FLUSH,  32'h1234_5678);   // nothing pending
    send_request(FUNC_UNUSED, 32'hAAAA_5555);   // undefined function
  endtask

  // Buffer on: parking, same-sector writes, buffer reads, displacement.
  task automatic test_write_buffer();
    write_buffer_cfg(1'b1);
    send_request(FUNC_WRITE, 32'h0000_0007);    // park 7
    send_request(FUNC_WRITE, 32'h0000_0007);    // same sector, one result
    send_request(FUNC_READ,  32'h0000_0007);    // read from buffer
    send_request(FUNC_WRITE, 32'h0000_0009);    // write out 7, park 9
    send_request(FUNC_WRITE, EMPTY_TAG);        // write out 9, buffer ends empty
    send_request(FUNC_FLUSH, 32'h0000_0000);    // nothing pending
    send_request(FUNC_READ,  EMPTY_TAG);        // no buffer hit on the marker
    send_request(FUNC_WRITE, 32'h0000_000B);    // park 11
    // Buffer off with 11 still parked: reads skip it, writes leave it alone.
    write_buffer_cfg(1'b0);
    send_request(FUNC_READ,  32'h0000_000B);
    send_request(FUNC_WRITE, 32'h0000_000C);
    send_request(FUNC_FLUSH, 32'h0000_0000);    // flush works with buffer off
    write_buffer_cfg(1'b1);
    send_request(FUNC_WRITE, 32'h0000_000D);
    write_buffer_cfg(1'b0);
    send_request(FUNC_FLUSH, 32'hFFFF_FFFF);    // writes out 13 by allocate
  endtask

  // Phases with the buffer on and off and varied flow control.
  task automatic test_random_mix();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_buffer_cfg((p < 2) ? logic'(p == 0) : logic'($urandom_range(0, 1)));
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random_request();
      end
    end
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // Sender stops and waits for every result, then resumes with no gaps.
  task automatic test_source_pause();
    for (int i = 0; i < 10; i++) send_random_request();
    drain_results();
    source_steady = 1'b1;
    for (int i = 0; i < 10; i++) send_random_request();
    source_steady = 1'b0;
  endtask

  // Sink holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    write_buffer_cfg(1'b1);
    hold_off_req  = 1'b1;
    source_steady = 1'b1;
    for (int i = 0; i < 16; i++) send_random_request();
    source_steady = 1'b0;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    for (int i = 0; i < SLOTS; i++) tag_dir[i] = EMPTY_TAG;
    ring_ptr        = 0;
    buffered_sector = EMPTY_TAG;
    wbuf_en         = 1'b0;
    errors          = 0;
    cycle_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    cfg_writes      = 0;
    for (int i = 0; i < 7; i++) action_count[i] = 0;
    source_steady   = 1'b0;
    sink_steady     = 1'b0;
    hold_off_req    = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_write_through();
    test_write_buffer();
    test_random_mix();
    test_source_pause();
    test_backpressure();

    // Let any straggling result show up before closing
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (action_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, action_q.size());
    end

    $display("tb: %0d requests, %0d results checked, %0d buffer enable writes",
             items_sent, results_checked, cfg_writes);
    $display("tb: buf-read %0d rd-hit %0d fill %0d wr-hit %0d alloc %0d parked %0d idle %0d",
             action_count[ACT_BUF_READ], action_count[ACT_READ_HIT],
             action_count[ACT_READ_FILL], action_count[ACT_WRITE_HIT],
             action_count[ACT_WRITE_ALLOC], action_count[ACT_BUFFERED],
             action_count[ACT_NOTHING]);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sector_cache_directory_fifo_core.f -----
design/sccd_pkg.sv
design/sccd_tag_cell.sv
design/sector_cache_directory_fifo_core.sv
tb/tb.sv
